// ===== sv/prefix_cache_hit_checksum_unit_macros.svh =====
// assertion macros for the prefix cache hit checksum unit
`ifndef PREFIX_CACHE_HIT_CHECKSUM_UNIT_MACROS_SVH
`define PREFIX_CACHE_HIT_CHECKSUM_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define PCH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define PCH_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/pch_pkg.sv =====
// shared types and constants of the prefix cache hit checksum unit
package pch_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_BLOCK  = 2'd1;
    localparam logic [1:0] CMD_EMPTY  = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;
    localparam logic [1:0] KIND_PREFIX = 2'd0;
    localparam logic [1:0] KIND_CSUM   = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MIX1, ST_MIX2, ST_MIX3, ST_MOD, ST_READ, ST_PROBE,
        ST_HASH1, ST_HASH2, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic clr_start;  // begin clearing sweep
        logic mix1;
        logic mix2;
        logic mix3;       // final mix and quotient estimate
        logic set_home;   // home slot ready
        logic step;       // advance probe
        logic ins_wr;     // write key into probed slot
        logic hit;        // record lookup hit
        logic miss;       // record lookup miss
        logic hash1;
        logic hash2;
        logic set_out;    // load result register
        logic [1:0] out_kind;
        logic fin_clear;  // reset hash and request state
    } pch_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic last;
        logic occ;        // probed slot occupied
        logic match;      // probed key equals item key
        logic probe_done; // all slots visited
        logic clr_done;
        logic still;
        logic out_busy;
    } pch_sts_t;
endpackage

// ===== sv/pch_ram.sv =====
// generic single-port-write ram with registered read
module pch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/pch_datapath.sv =====
// datapath: mixer, probe address, table rams, prefix and hash registers
module pch_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pch_pkg::pch_cmd_t cmd_i,
    output pch_pkg::pch_sts_t sts_o,
    input  logic [1:0]       in_cmd,
    input  logic [31:0]      in_key,
    input  logic             in_last,
    input  logic [15:0]      iter_count,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic [63:0]      m_value
);
    import pch_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam int RSH = 32 + $clog2(TABLE_DEPTH);
    localparam logic [65:0] RECIP = ((66'd1 << RSH) + 66'(TABLE_DEPTH) - 66'd1)
                                    / 66'(TABLE_DEPTH);

    logic [1:0]  cmd_reg;
    logic [31:0] key_reg;
    logic        last_reg;
    logic [31:0] mix_reg;
    logic [31:0] hv_reg;
    logic [31:0] q_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] nvis_reg;
    logic [AW-1:0] clr_reg;
    logic        clr_busy_reg;
    logic [31:0] prefix_reg;
    logic        still_reg;
    logic [63:0] hash_reg;
    logic [63:0] prod_reg;
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [63:0] m_value_reg;
    logic [31:0] key_rd;
    logic        occ_rd;
    logic [31:0] m1, m2;
    logic [31:0] home32;
    logic [65:0] qprod;
    logic [31:0] rem32;
    logic [AW-1:0] home;
    logic [AW-1:0] next_idx;
    logic [31:0] fold_val;

    // mixer stage values, one multiply per cycle
    assign m1 = key_reg ^ (key_reg >> 16);
    assign m2 = mix_reg ^ (mix_reg >> 15);
    assign home32 = mix_reg ^ (mix_reg >> 16);
    // home slot modulo depth: reciprocal multiply, quotient registered, then remainder
    assign qprod = {34'd0, home32} * RECIP;
    assign rem32 = hv_reg - q_reg * 32'(TABLE_DEPTH);
    assign home = rem32[AW-1:0];
    assign next_idx = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    // an empty request folds zero
    assign fold_val = (cmd_reg == CMD_EMPTY) ? 32'd0 : prefix_reg;

    // table rams
    pch_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_keys (
        .aclk(aclk), .we(cmd_i.ins_wr), .waddr(idx_reg), .wdata(key_reg),
        .raddr(idx_reg), .rdata(key_rd)
    );
    pch_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_occ (
        .aclk(aclk), .we(cmd_i.ins_wr || clr_busy_reg),
        .waddr(clr_busy_reg ? clr_reg : idx_reg), .wdata(!clr_busy_reg),
        .raddr(idx_reg), .rdata(occ_rd)
    );

    // item capture, mixer, probe index
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            cmd_reg  <= in_cmd;
            key_reg  <= in_key;
            last_reg <= in_last;
        end
        if (cmd_i.mix1) mix_reg <= m1 * MIX_C1;
        if (cmd_i.mix2) mix_reg <= m2 * MIX_C2;
        if (cmd_i.mix3) begin
            hv_reg <= home32;
            q_reg  <= 32'(qprod >> RSH);
        end
        if (cmd_i.set_home) begin
            idx_reg  <= home;
            nvis_reg <= '0;
        end else if (cmd_i.step) begin
            idx_reg  <= next_idx;
            nvis_reg <= nvis_reg + 1'b1;
        end
        if (cmd_i.hash1) prod_reg <= (hash_reg ^ {32'd0, fold_val}) * FNV_PRIME;
    end

    // clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_reg      <= '0;
        end else if (cmd_i.clr_start) begin
            clr_busy_reg <= 1'b1;
            clr_reg      <= '0;
        end else if (clr_busy_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == LAST_IDX) clr_busy_reg <= 1'b0;
        end
    end

    // request and hash state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
            still_reg  <= 1'b1;
            hash_reg   <= FNV_BASIS;
        end else begin
            if (cmd_i.hit && prefix_reg != '1) prefix_reg <= prefix_reg + 1'b1;
            if (cmd_i.miss) still_reg <= 1'b0;
            if (cmd_i.hash2) begin
                hash_reg <= prod_reg;
                if (cmd_reg == CMD_BLOCK) begin
                    prefix_reg <= '0;
                    still_reg  <= 1'b1;
                end
            end
            if (cmd_i.fin_clear) begin
                hash_reg   <= FNV_BASIS;
                prefix_reg <= '0;
                still_reg  <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.set_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd_i.set_out) begin
            m_kind_reg <= cmd_i.out_kind;
            case (cmd_i.out_kind)
                KIND_DROP: m_value_reg <= {32'd0, key_reg};
                KIND_CSUM: m_value_reg <= (iter_count == '0) ? 64'd0 : hash_reg;
                default:   m_value_reg <= (cmd_reg == CMD_EMPTY) ? 64'd0
                                          : {32'd0, prefix_reg};
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = m_value_reg;

    assign sts_o.cmd        = cmd_reg;
    assign sts_o.last       = last_reg;
    assign sts_o.occ        = occ_rd;
    assign sts_o.match      = (key_rd == key_reg);
    assign sts_o.probe_done = (nvis_reg == CW'(TABLE_DEPTH));
    assign sts_o.clr_done   = !clr_busy_reg;
    assign sts_o.still      = still_reg;
    assign sts_o.out_busy   = m_valid_reg && !m_ready;
endmodule

// ===== sv/pch_ctrl.sv =====
// controller state machine of the prefix cache hit checksum unit
`include "prefix_cache_hit_checksum_unit_macros.svh"
module pch_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pch_pkg::pch_sts_t sts_i,
    output pch_pkg::pch_cmd_t cmd_o
);
    import pch_pkg::*;
    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd_o = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: if (sts_i.clr_done) state_next = ST_IDLE;
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_MIX1;
                end
            end
            ST_MIX1: begin
                case (sts_i.cmd)
                    CMD_EMPTY: begin
                        cmd_o.hash1 = 1'b1;
                        state_next = ST_HASH2;
                    end
                    CMD_FINISH: state_next = ST_OUT;
                    CMD_BLOCK: begin
                        if (sts_i.still) begin
                            cmd_o.mix1 = 1'b1;
                            state_next = ST_MIX2;
                        end else if (sts_i.last) begin
                            cmd_o.hash1 = 1'b1;
                            state_next = ST_HASH2;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        cmd_o.mix1 = 1'b1;
                        state_next = ST_MIX2;
                    end
                endcase
            end
            ST_MIX2: begin
                cmd_o.mix2 = 1'b1;
                state_next = ST_MIX3;
            end
            ST_MIX3: begin
                cmd_o.mix3 = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd_o.set_home = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: state_next = ST_PROBE;
            ST_PROBE: begin
                if (sts_i.probe_done) begin
                    if (sts_i.cmd == CMD_INSERT) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd_o.miss = 1'b1;
                        state_next = ST_HASH1;
                    end
                end else if (!sts_i.occ) begin
                    if (sts_i.cmd == CMD_INSERT) begin
                        cmd_o.ins_wr = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd_o.miss = 1'b1;
                        state_next = ST_HASH1;
                    end
                end else if (sts_i.match) begin
                    if (sts_i.cmd == CMD_INSERT) state_next = ST_IDLE;
                    else begin
                        cmd_o.hit = 1'b1;
                        state_next = ST_HASH1;
                    end
                end else begin
                    cmd_o.step = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_HASH1: begin
                if (sts_i.last) begin
                    cmd_o.hash1 = 1'b1;
                    state_next = ST_HASH2;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HASH2: state_next = ST_OUT;
            ST_OUT: begin
                if (!sts_i.out_busy) begin
                    cmd_o.set_out = 1'b1;
                    case (sts_i.cmd)
                        CMD_INSERT: cmd_o.out_kind = KIND_DROP;
                        CMD_FINISH: cmd_o.out_kind = KIND_CSUM;
                        default:    cmd_o.out_kind = KIND_PREFIX;
                    endcase
                    if (sts_i.cmd == CMD_FINISH) begin
                        cmd_o.fin_clear = 1'b1;
                        cmd_o.clr_start = 1'b1;
                        state_next = ST_CLEAR;
                    end else if (sts_i.cmd == CMD_INSERT) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd_o.hash2 = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    `PCH_ASSERT_IMP(a_ready_idle, aclk, aresetn, in_ready, state_reg == ST_IDLE, "ready outside idle")
    `PCH_ASSERT_IMP(a_no_wr_clear, aclk, aresetn, state_reg == ST_CLEAR, !cmd_o.ins_wr, "insert in clear")
    `PCH_ASSERT_NXT(a_load_mix, aclk, aresetn, cmd_o.load, state_reg == ST_MIX1, "load without decode")
endmodule

// ===== sv/prefix_cache_hit_checksum_unit.sv =====
// top level: prefix cache hit checksum unit
// one transaction at a time: no new input is accepted until the previous transaction is done,
//   and lookups and inserts run a serial probe loop through the registered-read table
// after reset and after each finish the occupancy table is swept while no input is accepted;
//   iteration_count is set to 1 by reset and kept across a finish
module prefix_cache_hit_checksum_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // cmd[1:0], key[33:2], zero pad
    input  logic        s_tlast,  // last_of_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // result_value[63:0]
    output logic [1:0]  m_tuser,  // result_kind[1:0]
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import pch_pkg::*;
    pch_cmd_t cmd;
    pch_sts_t sts;
    logic [15:0] iter_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn)    iter_reg <= 16'd1;
        else if (cfg_we) iter_reg <= cfg_wdata;
    end

    pch_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .sts_i(sts), .cmd_o(cmd)
    );

    pch_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd_i(cmd), .sts_o(sts),
        .in_cmd(s_tdata[1:0]), .in_key(s_tdata[33:2]), .in_last(s_tlast),
        .iter_count(iter_reg), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_kind(m_tuser), .m_value(m_tdata)
    );
endmodule

// ===== sim/prefix_cache_hit_checksum_unit_checker.sv =====
// checker: watches both channels, predicts results and compares them
module prefix_cache_hit_checksum_unit_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import pch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
    } result_t;

    result_t     expected_results[$];
    logic [31:0] slot_key[TABLE_DEPTH];
    logic        slot_used[TABLE_DEPTH];
    logic [63:0] csum;
    logic [31:0] hits;
    logic        matching;
    logic [15:0] iter_cnt;

    // xor-shift-multiply mixer
    function automatic logic [31:0] mix(input logic [31:0] k);
        logic [31:0] x;
        x = k ^ (k >> 16);
        x = x * MIX_C1;
        x = x ^ (x >> 15);
        x = x * MIX_C2;
        return x ^ (x >> 16);
    endfunction

    function automatic void clear_set();
        for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
        csum = FNV_BASIS;
        hits = '0;
        matching = 1'b1;
    endfunction

    // linear probe: returns 1 when found, else free slot or -1 in free_idx
    function automatic logic probe(input logic [31:0] k, output int free_idx);
        int idx;
        idx = mix(k) % TABLE_DEPTH;
        free_idx = -1;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!slot_used[idx]) begin
                free_idx = idx;
                return 1'b0;
            end
            if (slot_key[idx] == k) return 1'b1;
            idx = (idx + 1) % TABLE_DEPTH;
        end
        return 1'b0;
    endfunction

    task automatic predict_item(input logic [1:0] cmd, input logic [31:0] k,
                                input logic last);
        int      fidx;
        logic    found;
        result_t r;
        case (cmd)
            CMD_INSERT: begin
                found = probe(k, fidx);
                if (!found && fidx >= 0) begin
                    slot_used[fidx] = 1'b1;
                    slot_key[fidx] = k;
                end else if (!found) begin
                    r.kind = KIND_DROP;
                    r.value = {32'd0, k};
                    expected_results.push_back(r);
                end
            end
            CMD_BLOCK: begin
                if (matching) begin
                    if (probe(k, fidx)) begin
                        if (hits != 32'hffff_ffff) hits = hits + 1;
                    end else begin
                        matching = 1'b0;
                    end
                end
                if (last) begin
                    r.kind = KIND_PREFIX;
                    r.value = {32'd0, hits};
                    expected_results.push_back(r);
                    csum = (csum ^ {32'd0, hits}) * FNV_PRIME;
                    hits = '0;
                    matching = 1'b1;
                end
            end
            CMD_EMPTY: begin
                r.kind = KIND_PREFIX;
                r.value = '0;
                expected_results.push_back(r);
                csum = csum * FNV_PRIME;
            end
            default: begin
                r.kind = KIND_CSUM;
                r.value = (iter_cnt == 16'd0) ? 64'd0 : csum;
                expected_results.push_back(r);
                clear_set();
            end
        endcase
    endtask

    // observe config writes, input transactions and result transactions
    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            clear_set();
            iter_cnt = 16'd1;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) iter_cnt = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_item(s_tdata[1:0], s_tdata[33:2], s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind %0d value %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    r = expected_results.pop_front();
                    if (m_tuser !== r.kind || m_tdata !== r.value) begin
                        $display("%0t: expected kind %0d value %h, got kind %0d value %h",
                                 $time, r.kind, r.value, m_tuser, m_tdata);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end
endmodule

// ===== sim/tb_prefix_cache_hit_checksum_unit.sv =====
// testbench top: stimulus, idling control and verdict
module tb_prefix_cache_hit_checksum_unit;
    import pch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int SETTLE = 2 * DEPTH + 200;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;
    longint      cycles = 0;
    logic [31:0] key_pool[32];

    prefix_cache_hit_checksum_unit #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    prefix_cache_hit_checksum_unit_checker #(.TABLE_DEPTH(DEPTH)) checker_i (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one input transaction, with random gaps ahead of it
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] k,
                             input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata <= 40'({$urandom, $urandom});
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, k, cmd};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until all results are back and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_iter(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // a session of inserts and requests, mostly from the key pool, closed by finish
    task automatic run_session();
        int n;
        logic [31:0] k;
        for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
        n = $urandom_range(3, 14);
        for (int i = 0; i < n; i++)
            send_item(CMD_INSERT, key_pool[$urandom_range(0, 20)], 1'($urandom_range(1)));
        n = $urandom_range(2, 8);
        for (int q = 0; q < n; q++) begin
            int len;
            len = $urandom_range(1, 6);
            for (int b = 0; b < len; b++) begin
                k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(0, 22)];
                case ($urandom_range(19))
                    0: send_item(CMD_EMPTY, $urandom, 1'($urandom_range(1)));
                    1: send_item(CMD_INSERT, k, 1'($urandom_range(1)));
                    default: ;
                endcase
                send_item(CMD_BLOCK, k, b == len - 1);
            end
        end
        if ($urandom_range(3) == 0)
            send_item(CMD_BLOCK, key_pool[$urandom_range(0, 31)], 1'b0);
        send_item(CMD_FINISH, $urandom, 1'($urandom_range(1)));
    endtask

    initial begin
        logic [31:0] base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, duplicates, miss, blocks after a miss, empty requests
        write_iter(16'd1);
        send_item(CMD_INSERT, 32'h0000_0000, 1'b0);
        send_item(CMD_INSERT, 32'hffff_ffff, 1'b1);
        send_item(CMD_INSERT, 32'hffff_ffff, 1'b0);
        send_item(CMD_BLOCK, 32'h0000_0000, 1'b0);
        send_item(CMD_BLOCK, 32'hffff_ffff, 1'b0);
        send_item(CMD_BLOCK, 32'h1234_5678, 1'b0);
        send_item(CMD_BLOCK, 32'h0000_0000, 1'b1);
        send_item(CMD_EMPTY, 32'hffff_ffff, 1'b1);
        send_item(CMD_BLOCK, 32'h0000_0000, 1'b0);
        send_item(CMD_EMPTY, 32'h0, 1'b0);
        send_item(CMD_BLOCK, 32'hffff_ffff, 1'b1);
        send_item(CMD_BLOCK, 32'hdead_beef, 1'b1);
        send_item(CMD_FINISH, 32'h0, 1'b0);
        send_item(CMD_BLOCK, 32'h0000_0000, 1'b1);
        send_item(CMD_FINISH, 32'hffff_ffff, 1'b1);
        write_iter(16'd0);
        send_item(CMD_INSERT, 32'h8000_0001, 1'b0);
        send_item(CMD_BLOCK, 32'h8000_0001, 1'b1);
        send_item(CMD_FINISH, 32'h0, 1'b0);

        // random sessions under three idling patterns and several settings
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 18 : (ph == 1) ? 58 : 0;
            recv_idle = (ph == 0) ? 58 : (ph == 1) ? 18 : 0;
            write_iter(ph == 0 ? 16'hffff : ph == 1 ? 16'($urandom_range(2, 65534)) : 16'd1);
            for (int s = 0; s < 4; s++) begin
                if (s == 2) write_iter($urandom_range(3) == 0 ? 16'd0 : 16'($urandom));
                run_session();
            end
        end

        // full table: fill every slot, then drop, duplicate and full lookups
        write_iter(16'd7);
        base = $urandom;
        for (int i = 0; i < DEPTH; i++)
            send_item(CMD_INSERT, base + 32'(i) * 32'h9e37_79b1, 1'b0);
        send_item(CMD_INSERT, base + 32'(DEPTH) * 32'h9e37_79b1, 1'b0);
        send_item(CMD_INSERT, base, 1'b1);
        send_item(CMD_BLOCK, base + 32'h9e37_79b1, 1'b0);
        send_item(CMD_BLOCK, base + 32'(DEPTH + 1) * 32'h9e37_79b1, 1'b0);
        send_item(CMD_BLOCK, base, 1'b1);
        send_item(CMD_BLOCK, base + 32'(DEPTH + 2) * 32'h9e37_79b1, 1'b1);
        send_item(CMD_FINISH, 32'h0, 1'b0);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/pch_pkg.sv
sv/pch_ram.sv
sv/pch_datapath.sv
sv/pch_ctrl.sv
sv/prefix_cache_hit_checksum_unit.sv
sim/prefix_cache_hit_checksum_unit_checker.sv
sim/tb_prefix_cache_hit_checksum_unit.sv
